### rtl/core/deq_pkg.sv
package deq_pkg;

    typedef enum logic [2:0] {
        OP_PUSH_BACK  = 3'd0,
        OP_PUSH_FRONT = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_LIST       = 3'd4
    } deq_op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } deq_status_t;

    // Move that every cell of the chain makes at once.
    typedef enum logic [2:0] {
        MODE_HOLD,
        MODE_SHIFT_IN,
        MODE_SHIFT_OUT,
        MODE_PUT,
        MODE_ROTATE
    } deq_mode_t;

    typedef enum logic {
        S_IDLE,
        S_LIST
    } deq_state_t;

endpackage

### rtl/core/deq_cell.sv
module deq_cell #(
    parameter int IDX = 0,
    parameter int CW  = 5
) (
    input  logic               clk,
    input  deq_pkg::deq_mode_t mode,
    input  logic [CW-1:0]      count,
    input  logic [31:0]        left_data,
    input  logic [31:0]        right_data,
    input  logic [31:0]        ins_data,
    output logic [31:0]        data
);
    import deq_pkg::*;

    localparam logic [CW-1:0] POS      = CW'(IDX);
    localparam logic [CW-1:0] POS_NEXT = CW'(IDX + 1);

    logic [31:0] data_reg;
    logic [31:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        case (mode)
            MODE_SHIFT_IN:  data_next = left_data;
            MODE_SHIFT_OUT: data_next = right_data;
            MODE_PUT:
            begin
                if (count == POS)
                    data_next = ins_data;
            end
            MODE_ROTATE:
            begin
                // The tail cell takes the front value; cells ahead of it move one step forward.
                if (count == POS_NEXT)
                    data_next = ins_data;
                else if (POS_NEXT < count)
                    data_next = right_data;
            end
            default: data_next = data_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

### rtl/core/double_ended_queue_top.sv
// Double-ended queue of DEPTH signed 32-bit values held in a chain of cells, with the front
// entry always in the first cell. A request is taken when start is high and busy is low.
// Push back, push front, pop front and pop back leave busy low, so such requests can be
// issued every cycle. A list request walks the held entries by rotating the chain one cell per
// cycle with busy high, giving one result per held entry (one empty result if none is held).
// Each result is registered, appears in the cycle after the step that makes it and is shown
// on the result ports for a single cycle with valid high; the receiver cannot stall it, and
// last marks a request's final result; unused op codes give no result and change nothing.
module double_ended_queue_top #(
    parameter int DEPTH = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         op,
    input  logic signed [31:0] value,
    output logic               valid,
    output logic signed [31:0] value_res,
    output logic [1:0]         status,
    output logic               last
);
    import deq_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    deq_state_t  state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] rem_reg, rem_next;
    logic          valid_reg, valid_next;
    logic [31:0]   value_res_reg, value_res_next;
    deq_status_t   status_reg, status_next;
    logic          last_reg, last_next;

    deq_mode_t     mode;
    logic [31:0]   ins_data;
    logic [31:0]   cell_data [DEPTH];
    logic [IW-1:0] tail_idx;
    logic          accept;

    assign accept   = start && (state_reg == S_IDLE);
    assign tail_idx = IW'(count_reg - CW'(1));

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            logic [31:0] left_in;
            logic [31:0] right_in;
            if (g == 0)
            begin : g_first
                assign left_in = value;
            end
            else
            begin : g_mid_l
                assign left_in = cell_data[g-1];
            end
            if (g == DEPTH - 1)
            begin : g_last
                assign right_in = cell_data[g];
            end
            else
            begin : g_mid_r
                assign right_in = cell_data[g+1];
            end
            deq_cell #(
                .IDX (g),
                .CW  (CW)
            ) u_cell (
                .clk        (clk),
                .mode       (mode),
                .count      (count_reg),
                .left_data  (left_in),
                .right_data (right_in),
                .ins_data   (ins_data),
                .data       (cell_data[g])
            );
        end
    endgenerate

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && deq_op_t'(op) == OP_LIST && count_reg != '0)
                    state_next = S_LIST;
            end
            S_LIST:
            begin
                if (rem_reg == CW'(1))
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Chain control and results.
    always_comb
    begin
        mode           = MODE_HOLD;
        ins_data       = value;
        count_next     = count_reg;
        rem_next       = rem_reg;
        valid_next     = 1'b0;
        value_res_next = '0;
        status_next    = ST_OK;
        last_next      = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (deq_op_t'(op))
                        OP_PUSH_BACK, OP_PUSH_FRONT:
                        begin
                            valid_next = 1'b1;
                            if (count_reg == FULL_COUNT)
                                status_next = ST_FULL;
                            else
                            begin
                                mode       = (deq_op_t'(op) == OP_PUSH_BACK) ? MODE_PUT
                                                                              : MODE_SHIFT_IN;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        OP_POP_FRONT, OP_POP_BACK:
                        begin
                            valid_next = 1'b1;
                            if (count_reg == '0)
                                status_next = ST_EMPTY;
                            else
                            begin
                                count_next = count_reg - CW'(1);
                                if (deq_op_t'(op) == OP_POP_FRONT)
                                begin
                                    mode           = MODE_SHIFT_OUT;
                                    value_res_next = cell_data[0];
                                end
                                else
                                    value_res_next = cell_data[tail_idx];
                            end
                        end
                        OP_LIST:
                        begin
                            if (count_reg == '0)
                            begin
                                valid_next  = 1'b1;
                                status_next = ST_EMPTY;
                            end
                            else
                                rem_next = count_reg;
                        end
                        default: valid_next = 1'b0;
                    endcase
                end
            end
            S_LIST:
            begin
                // After as many rotations as held entries the chain is back in order.
                mode           = MODE_ROTATE;
                ins_data       = cell_data[0];
                valid_next     = 1'b1;
                value_res_next = cell_data[0];
                last_next      = (rem_reg == CW'(1));
                rem_next       = rem_reg - CW'(1);
            end
            default: mode = MODE_HOLD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            rem_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            rem_reg   <= rem_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_res_reg <= value_res_next;
        status_reg    <= status_next;
        last_reg      <= last_next;
    end

    assign busy      = (state_reg == S_LIST);
    assign valid     = valid_reg;
    assign value_res = value_res_reg;
    assign status    = status_reg;
    assign last      = last_reg;

endmodule

### tb/double_ended_queue_top_tb.sv
module double_ended_queue_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import deq_pkg::*;

    localparam int DEPTH        = 16;
    localparam int RANDOM_ITEMS = 112;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int PRINT_CAP    = 40;

    typedef struct {
        logic signed [31:0] value_res;
        deq_status_t        status;
        logic               last;
    } deq_result_t;

    typedef struct {
        logic [2:0]         op;
        logic signed [31:0] value;
        int                 reps;
        bit                 typed;
        logic signed [31:0] exp_value;
        deq_status_t        exp_status;
    } stim_row_t;

    localparam int N_DIRECTED = 22;

    // Rows marked typed carry their own expected result; the rest are predicted.
    stim_row_t directed [N_DIRECTED] = '{
        '{OP_POP_FRONT,  32'sh0000_0000, 1, 1'b1, 32'sd0, ST_EMPTY},
        '{OP_POP_BACK,   32'sh0000_0000, 1, 1'b1, 32'sd0, ST_EMPTY},
        '{OP_LIST,       32'sh0000_0000, 1, 1'b1, 32'sd0, ST_EMPTY},
        '{OP_PUSH_BACK,  32'sh7FFF_FFFF, 1, 1'b0, 32'sd0, ST_OK},
        '{OP_PUSH_FRONT, 32'sh8000_0000, 1, 1'b0, 32'sd0, ST_OK},
        '{OP_PUSH_BACK,  32'shFFFF_FFFF, 1, 1'b0, 32'sd0, ST_OK},
        '{OP_PUSH_FRONT, 32'sh0000_0000, 1, 1'b0, 32'sd0, ST_OK},
        '{OP_LIST,       32'sh0000_0000, 1, 1'b0, 32'sd0, ST_OK},
        '{OP_POP_FRONT,  32'sh0000_0000, 1, 1'b0, 32'sd0, ST_OK},
        '{OP_POP_BACK,   32'sh0000_0000, 1, 1'b0, 32'sd0, ST_OK},
        '{3'd5,          32'sh0000_0000, 1, 1'b0, 32'sd0, ST_OK},
        '{3'd7,          32'shFFFF_FFFF, 1, 1'b0, 32'sd0, ST_OK},
        '{OP_PUSH_BACK,  32'shAAAA_AAAA, 7, 1'b0, 32'sd0, ST_OK},
        '{OP_PUSH_FRONT, 32'sh5555_5555, 7, 1'b0, 32'sd0, ST_OK},
        '{OP_PUSH_BACK,  32'sh0000_0001, 1, 1'b1, 32'sd0, ST_FULL},
        '{OP_PUSH_FRONT, 32'sh0000_0001, 1, 1'b1, 32'sd0, ST_FULL},
        '{3'd6,          32'sh1234_5678, 1, 1'b0, 32'sd0, ST_OK},
        '{OP_LIST,       32'sh0000_0000, 1, 1'b0, 32'sd0, ST_OK},
        '{OP_POP_BACK,   32'sh0000_0000, 9, 1'b0, 32'sd0, ST_OK},
        '{OP_POP_FRONT,  32'sh0000_0000, 7, 1'b0, 32'sd0, ST_OK},
        '{OP_POP_BACK,   32'sh0000_0000, 1, 1'b1, 32'sd0, ST_EMPTY},
        '{OP_PUSH_FRONT, 32'sh1234_5678, 1, 1'b0, 32'sd0, ST_OK}
    };

    logic               clk;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic [2:0]         op    = 3'd0;
    logic signed [31:0] value = 32'sd0;
    logic               busy;
    logic               valid;
    logic signed [31:0] value_res;
    logic [1:0]         status;
    logic               last;

    double_ended_queue_top #(
        .DEPTH(DEPTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .op       (op),
        .value    (value),
        .valid    (valid),
        .value_res(value_res),
        .status   (status),
        .last     (last)
    );

    // Shadow model of the queue contents, held as a ring store.
    logic signed [31:0] ring_slots [DEPTH];
    int                 front_pos  = 0;
    int                 held_count = 0;

    deq_result_t pending_results[$];
    int          mismatches  = 0;
    int          cycle_count = 0;
    int          burst_left  = 0;
    bit          start_high  = 1'b0;
    bit          filling     = 1'b1;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic void deq_predict(input logic [2:0] o, input logic signed [31:0] v,
                                        output deq_result_t res[$]);
        res = {};
        case (o)
            OP_PUSH_BACK, OP_PUSH_FRONT:
            begin
                if (held_count == DEPTH)
                begin
                    res.push_back('{32'sd0, ST_FULL, 1'b1});
                end
                else
                begin
                    if (o == OP_PUSH_BACK)
                    begin
                        ring_slots[(front_pos + held_count) % DEPTH] = v;
                    end
                    else
                    begin
                        front_pos = (front_pos + DEPTH - 1) % DEPTH;
                        ring_slots[front_pos] = v;
                    end
                    held_count++;
                    res.push_back('{32'sd0, ST_OK, 1'b1});
                end
            end
            OP_POP_FRONT, OP_POP_BACK:
            begin
                if (held_count == 0)
                begin
                    res.push_back('{32'sd0, ST_EMPTY, 1'b1});
                end
                else if (o == OP_POP_FRONT)
                begin
                    res.push_back('{ring_slots[front_pos], ST_OK, 1'b1});
                    front_pos = (front_pos + 1) % DEPTH;
                    held_count--;
                end
                else
                begin
                    res.push_back('{ring_slots[(front_pos + held_count - 1) % DEPTH],
                                    ST_OK, 1'b1});
                    held_count--;
                end
            end
            OP_LIST:
            begin
                if (held_count == 0)
                begin
                    res.push_back('{32'sd0, ST_EMPTY, 1'b1});
                end
                else
                begin
                    for (int i = 0; i < held_count; i++)
                    begin
                        res.push_back('{ring_slots[(front_pos + i) % DEPTH], ST_OK,
                                        logic'(i == held_count - 1)});
                    end
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= PRINT_CAP)
        begin
            $display("[%0d] mismatch: %s", cycle_count, msg);
        end
    endtask

    // Results are sampled at the edge that ends their one valid cycle.
    always @(posedge clk)
    begin
        deq_result_t want;
        if (rst_n && valid)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result value %0d status %0d last %0b",
                                          value_res, status, last));
            end
            else
            begin
                want = pending_results.pop_front();
                if (value_res !== want.value_res || status !== want.status
                    || last !== want.last)
                begin
                    report_mismatch($sformatf(
                        "got value %0d status %0d last %0b, want %0d %0d %0b",
                        value_res, status, last, want.value_res, want.status, want.last));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout with %0d results outstanding", pending_results.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Drives one request and waits for it to be taken, then applies the burst pacing.
    task automatic issue_request(input logic [2:0] o, input logic signed [31:0] v,
                                 input bit typed, input deq_result_t typed_res);
        deq_result_t res[$];
        start      <= 1'b1;
        op         <= o;
        value      <= v;
        start_high  = 1'b1;
        do
            @(posedge clk);
        while (busy);
        deq_predict(o, v, res);
        if (typed)
        begin
            res.delete();
            res.push_back(typed_res);
        end
        foreach (res[i])
        begin
            pending_results.push_back(res[i]);
        end
        burst_left--;
        if (burst_left <= 0)
        begin
            start      <= 1'b0;
            op         <= 3'($urandom);
            value      <= $urandom;
            start_high  = 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(4) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(1, 8);
        end
    endtask

    function automatic logic signed [31:0] random_value();
        case ($urandom_range(9))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return 32'sd0;
            default: return $urandom;
        endcase
    endfunction

    // Biased towards pushes while filling and towards pops while draining, so the
    // store keeps sweeping between empty and full.
    function automatic logic [2:0] pick_op();
        int r;
        r = $urandom_range(99);
        if (r < 3)
        begin
            return 3'($urandom_range(7, 5));
        end
        if (r < 13)
        begin
            return OP_LIST;
        end
        if (($urandom_range(99) < 75) == filling)
        begin
            return $urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
        end
        return $urandom_range(1) ? OP_POP_FRONT : OP_POP_BACK;
    endfunction

    initial
    begin
        deq_result_t typed_res;
        logic [2:0]  o;
        int          issued;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        burst_left = $urandom_range(1, 8);

        foreach (directed[k])
        begin
            typed_res = '{directed[k].exp_value, directed[k].exp_status, 1'b1};
            for (int r = 0; r < directed[k].reps; r++)
            begin
                issue_request(directed[k].op, directed[k].value ^ r, directed[k].typed,
                              typed_res);
            end
        end

        issued = 0;
        while (issued < RANDOM_ITEMS)
        begin
            if (held_count == DEPTH)
            begin
                filling = 1'b0;
            end
            else if (held_count == 0)
            begin
                filling = 1'b1;
            end
            else if ($urandom_range(19) == 0)
            begin
                filling = ~filling;
            end
            o = pick_op();
            issue_request(o, random_value(), 1'b0, typed_res);
            if (o <= OP_LIST)
            begin
                issued++;
            end
        end

        if (start_high)
        begin
            start <= 1'b0;
        end
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DEPTH + 4) @(posedge clk);

        if (mismatches == 0 && pending_results.size() == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
